[rtl/core/lr_pkg.sv]
package lr_pkg;

    localparam int COORD_BITS_DEF = 10;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } lr_op_t;

endpackage

[rtl/core/lr_setup.sv]
module lr_setup #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    output logic                  major_is_x,
    output logic [COORD_BITS-1:0] major_first,
    output logic [COORD_BITS-1:0] major_last,
    output logic [COORD_BITS-1:0] minor_first,
    output logic [COORD_BITS-1:0] minor_delta,
    output logic                  minor_descending,
    output logic [COORD_BITS-1:0] major_delta
);
    import lr_pkg::*;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] a0;
    logic [COORD_BITS-1:0] a1;
    logic [COORD_BITS-1:0] b0;
    logic [COORD_BITS-1:0] b1;

    assign dx = (x_start >= x_end) ? (x_start - x_end) : (x_end - x_start);
    assign dy = (y_start >= y_end) ? (y_start - y_end) : (y_end - y_start);
    assign major_is_x = (dx >= dy);

    always_comb begin
        if (major_is_x) begin
            a0 = x_start;
            a1 = x_end;
            b0 = y_start;
            b1 = y_end;
        end else begin
            a0 = y_start;
            a1 = y_end;
            b0 = x_start;
            b1 = x_end;
        end
    end

    // walk from the lower major coordinate; on a tie take the second endpoint
    always_comb begin
        if (a1 > a0) begin
            major_first      = a0;
            major_last       = a1;
            minor_first      = b0;
            minor_descending = (b1 < b0);
        end else begin
            major_first      = a1;
            major_last       = a0;
            minor_first      = b1;
            minor_descending = (b0 < b1);
        end
    end

    assign major_delta = major_last - major_first;
    assign minor_delta = major_is_x ? dy : dx;

endmodule

[rtl/core/lr_stepper.sv]
module lr_stepper #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  lr_pkg::lr_op_t        opcode,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    output logic                  res_valid,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);
    import lr_pkg::*;

    localparam int REM_BITS = COORD_BITS + 1;

    logic                  line_active_reg, line_active_next;
    logic                  major_is_x_reg, major_is_x_next;
    logic [COORD_BITS-1:0] major_position_reg, major_position_next;
    logic [COORD_BITS-1:0] major_limit_reg, major_limit_next;
    logic [COORD_BITS-1:0] minor_whole_reg, minor_whole_next;
    logic [REM_BITS-1:0]   minor_remainder_reg, minor_remainder_next;
    logic [COORD_BITS-1:0] minor_delta_reg, minor_delta_next;
    logic                  minor_descending_reg, minor_descending_next;
    logic [COORD_BITS-1:0] major_delta_reg, major_delta_next;

    logic                  su_major_is_x;
    logic [COORD_BITS-1:0] su_major_first;
    logic [COORD_BITS-1:0] su_major_last;
    logic [COORD_BITS-1:0] su_minor_first;
    logic [COORD_BITS-1:0] su_minor_delta;
    logic                  su_minor_descending;
    logic [COORD_BITS-1:0] su_major_delta;

    logic                  at_last;
    logic                  round_up;
    logic [COORD_BITS-1:0] rounded;
    logic [REM_BITS-1:0]   minor_delta_ext;
    logic [REM_BITS-1:0]   major_delta_ext;
    logic [REM_BITS-1:0]   asc_sum;

    lr_setup #(
        .COORD_BITS(COORD_BITS)
    ) u_setup (
        .x_start          (x_start),
        .y_start          (y_start),
        .x_end            (x_end),
        .y_end            (y_end),
        .major_is_x       (su_major_is_x),
        .major_first      (su_major_first),
        .major_last       (su_major_last),
        .minor_first      (su_minor_first),
        .minor_delta      (su_minor_delta),
        .minor_descending (su_minor_descending),
        .major_delta      (su_major_delta)
    );

    assign minor_delta_ext = {1'b0, minor_delta_reg};
    assign major_delta_ext = {1'b0, major_delta_reg};
    assign asc_sum         = minor_remainder_reg + minor_delta_ext;

    assign at_last  = (major_position_reg == major_limit_reg);
    assign round_up = (major_delta_reg != '0) &&
                      ({minor_remainder_reg, 1'b0} >= {1'b0, major_delta_ext});
    assign rounded  = round_up ? (minor_whole_reg + 1'b1) : minor_whole_reg;

    assign res_valid  = (opcode == OP_STEP) && line_active_reg;
    assign pixel_x    = major_is_x_reg ? major_position_reg : rounded;
    assign pixel_y    = major_is_x_reg ? rounded : major_position_reg;
    assign last_pixel = at_last;

    always_comb begin
        line_active_next      = line_active_reg;
        major_is_x_next       = major_is_x_reg;
        major_position_next   = major_position_reg;
        major_limit_next      = major_limit_reg;
        minor_whole_next      = minor_whole_reg;
        minor_remainder_next  = minor_remainder_reg;
        minor_delta_next      = minor_delta_reg;
        minor_descending_next = minor_descending_reg;
        major_delta_next      = major_delta_reg;
        if (fire) begin
            case (opcode)
                OP_START: begin
                    line_active_next      = 1'b1;
                    major_is_x_next       = su_major_is_x;
                    major_position_next   = su_major_first;
                    major_limit_next      = su_major_last;
                    minor_whole_next      = su_minor_first;
                    minor_remainder_next  = '0;
                    minor_delta_next      = su_minor_delta;
                    minor_descending_next = su_minor_descending;
                    major_delta_next      = su_major_delta;
                end
                OP_STEP: begin
                    if (line_active_reg) begin
                        if (at_last) begin
                            line_active_next = 1'b0;
                        end else begin
                            major_position_next = major_position_reg + 1'b1;
                            if (!minor_descending_reg) begin
                                if (asc_sum >= major_delta_ext) begin
                                    minor_remainder_next = asc_sum - major_delta_ext;
                                    minor_whole_next     = minor_whole_reg + 1'b1;
                                end else begin
                                    minor_remainder_next = asc_sum;
                                end
                            end else begin
                                if (minor_remainder_reg >= minor_delta_ext) begin
                                    minor_remainder_next = minor_remainder_reg - minor_delta_ext;
                                end else begin
                                    // borrow one whole unit from the minor coordinate
                                    minor_remainder_next = minor_remainder_reg
                                                         + major_delta_ext - minor_delta_ext;
                                    minor_whole_next     = minor_whole_reg - 1'b1;
                                end
                            end
                        end
                    end
                end
                default: begin
                    line_active_next = line_active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_active_reg <= 1'b0;
        end else begin
            line_active_reg <= line_active_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            major_is_x_reg       <= 1'b0;
            major_position_reg   <= '0;
            major_limit_reg      <= '0;
            minor_whole_reg      <= '0;
            minor_remainder_reg  <= '0;
            minor_delta_reg      <= '0;
            minor_descending_reg <= 1'b0;
            major_delta_reg      <= '0;
        end else begin
            major_is_x_reg       <= major_is_x_next;
            major_position_reg   <= major_position_next;
            major_limit_reg      <= major_limit_next;
            minor_whole_reg      <= minor_whole_next;
            minor_remainder_reg  <= minor_remainder_next;
            minor_delta_reg      <= minor_delta_next;
            minor_descending_reg <= minor_descending_next;
            major_delta_reg      <= major_delta_next;
        end
    end

    a_rem_below_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_active_reg && (major_delta_reg != '0)) |->
            (minor_remainder_reg < major_delta_ext))
        else $error("minor remainder reached major delta");

    a_minor_not_major: assert property (@(posedge aclk) disable iff (!aresetn)
        line_active_reg |-> (minor_delta_reg <= major_delta_reg))
        else $error("minor delta exceeds major delta");

    a_position_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        line_active_reg |-> (major_position_reg <= major_limit_reg))
        else $error("major position passed the limit");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res_valid && at_last) |=> !line_active_reg)
        else $error("line still active after last pixel");

endmodule

[rtl/core/incremental_line_rasterizer.sv]
// An input transfer lands in the input register; when the output register has
// room, its pixel, if it yields one, moves into the output register, which drives
// m_tvalid. Throughput: one item per cycle while m_tready holds, set by the
// error-term update that feeds the line state back into itself.
// Reset (aresetn low, synchronous): no line active, both registers empty.
module incremental_line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // x_start, y_start, x_end, y_end from bit 0 up, zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    // opcode
    input  logic [0:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // pixel_x, pixel_y from bit 0 up, zero padded
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    output logic                                  m_tlast
);
    import lr_pkg::*;

    localparam int S_DATA_W = ((4*COORD_BITS+7)/8)*8;
    localparam int M_DATA_W = ((2*COORD_BITS+7)/8)*8;
    localparam int M_PAD_W  = M_DATA_W - 2*COORD_BITS;

    logic                  in_valid_reg;
    lr_op_t                in_op_reg;
    logic [S_DATA_W-1:0]   in_data_reg;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_last_reg;

    logic                  advance;
    logic                  res_valid;
    logic [COORD_BITS-1:0] res_x;
    logic [COORD_BITS-1:0] res_y;
    logic                  res_last;

    // item in the input register moves on when the output register has room
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg   <= lr_op_t'(s_tuser[0]);
            in_data_reg <= s_tdata;
        end
    end

    lr_stepper #(
        .COORD_BITS(COORD_BITS)
    ) u_stepper (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (advance),
        .opcode     (in_op_reg),
        .x_start    (in_data_reg[0*COORD_BITS +: COORD_BITS]),
        .y_start    (in_data_reg[1*COORD_BITS +: COORD_BITS]),
        .x_end      (in_data_reg[2*COORD_BITS +: COORD_BITS]),
        .y_end      (in_data_reg[3*COORD_BITS +: COORD_BITS]),
        .res_valid  (res_valid),
        .pixel_x    (res_x),
        .pixel_y    (res_y),
        .last_pixel (res_last)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_x_reg    <= res_x;
            out_y_reg    <= res_y;
            out_last_reg <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;

    generate
        if (M_PAD_W > 0) begin : g_pad
            assign m_tdata = {{M_PAD_W{1'b0}}, out_y_reg, out_x_reg};
        end else begin : g_nopad
            assign m_tdata = {out_y_reg, out_x_reg};
        end
    endgenerate

endmodule

[dv/incremental_line_rasterizer_tb.sv]
`timescale 1ns / 1ps

module incremental_line_rasterizer_tb;
    import lr_pkg::*;

    localparam int COORD = lr_pkg::COORD_BITS_DEF;
    localparam int S_W = ((4*COORD+7)/8)*8;
    localparam int M_W = ((2*COORD+7)/8)*8;
    localparam int CMAX = (1 << COORD) - 1;
    // Longest quiet stretch of a correct run is the sink hold-off plus a few
    // sender gaps; allow several times that.
    localparam int STUCK_LIMIT = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef logic [COORD-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   is_last;
    } pixel_t;

    // How a directed row is checked: by the line predictor, as no result, or
    // against a typed pixel.
    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_PIXEL = 2'd2
    } chk_t;

    typedef struct packed {
        lr_op_t op;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        chk_t   chk;
        pixel_t px;
    } dir_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic [0:0]     s_tuser = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic           m_tlast;

    chk_t   item_chk = CHK_MODEL;
    pixel_t item_px = '0;
    int     src_idle = 13;
    int     sink_idle = 62;
    logic   hold_go = 1'b0;
    logic   hold_sink = 1'b0;
    int     mismatches = 0;
    int     stuck_cycles = 0;
    pixel_t pixel_q[$];
    dir_row_t dir_tbl[$];

    // line predictor state
    logic   line_on = 1'b0;
    logic   along_x = 1'b0;
    logic   minor_down = 1'b0;
    coord_t pos = '0;
    coord_t lim = '0;
    coord_t whole = '0;
    coord_t dminor = '0;
    coord_t dmajor = '0;
    logic [COORD:0] rem = '0;

    incremental_line_rasterizer #(
        .COORD_BITS (COORD)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic coord_t span(input coord_t a, input coord_t b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Next pixel of the current line, or line setup on a start.
    task automatic trace_item(input lr_op_t op, input logic [S_W-1:0] d,
                              output bit emits, output pixel_t px);
        coord_t x0, y0, x1, y1, a0, a1, b0, b1, rounded;
        emits = 1'b0;
        px = '0;
        x0 = d[COORD-1:0];
        y0 = d[2*COORD-1:COORD];
        x1 = d[3*COORD-1:2*COORD];
        y1 = d[4*COORD-1:3*COORD];
        if (op == OP_START) begin
            along_x = span(x0, x1) >= span(y0, y1);
            if (along_x) begin
                a0 = x0; a1 = x1; b0 = y0; b1 = y1;
            end else begin
                a0 = y0; a1 = y1; b0 = x0; b1 = x1;
            end
            // on a tie of the major coordinate the second endpoint leads
            if (a1 > a0) begin
                pos = a0; lim = a1; whole = b0; minor_down = b1 < b0;
            end else begin
                pos = a1; lim = a0; whole = b1; minor_down = b0 < b1;
            end
            dmajor = lim - pos;
            dminor = span(b0, b1);
            rem = '0;
            line_on = 1'b1;
        end else if (line_on) begin
            rounded = whole;
            if (dmajor != 0 && {rem, 1'b0} >= {2'b00, dmajor})
                rounded = whole + 1'b1;
            emits = 1'b1;
            px.x = along_x ? pos : rounded;
            px.y = along_x ? rounded : pos;
            px.is_last = (pos == lim);
            if (px.is_last) begin
                line_on = 1'b0;
            end else begin
                pos = pos + 1'b1;
                if (!minor_down) begin
                    rem = rem + dminor;
                    if (rem >= dmajor) begin
                        rem = rem - dmajor;
                        whole = whole + 1'b1;
                    end
                end else if (rem >= dminor) begin
                    rem = rem - dminor;
                end else begin
                    rem = rem + dmajor - dminor;
                    whole = whole - 1'b1;
                end
            end
        end
    endtask

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Check results first, then record what the accepted input will produce.
    always @(posedge aclk) begin : scoreboard
        bit     emits;
        pixel_t px;
        pixel_t got;
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.x = m_tdata[COORD-1:0];
            got.y = m_tdata[2*COORD-1:COORD];
            got.is_last = m_tlast;
            if (pixel_q.size() == 0) begin
                flag_error($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                     got.x, got.y, got.is_last));
            end else begin
                want = pixel_q.pop_front();
                if (got.x !== want.x)
                    flag_error($sformatf("pixel_x exp %0d got %0d", want.x, got.x));
                if (got.y !== want.y)
                    flag_error($sformatf("pixel_y exp %0d got %0d", want.y, got.y));
                if (got.is_last !== want.is_last)
                    flag_error($sformatf("last_pixel exp %0b got %0b",
                                         want.is_last, got.is_last));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            trace_item(lr_op_t'(s_tuser[0]), s_tdata, emits, px);
            case (item_chk)
                CHK_MODEL: if (emits) pixel_q.push_back(px);
                CHK_PIXEL: pixel_q.push_back(item_px);
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (hold_sink)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_idle);
    end

    // Long sink hold-off while the sender keeps offering items.
    initial begin
        while (!hold_go) @(posedge aclk);
        hold_sink <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_sink <= 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("[incremental_line_rasterizer] ERROR");
            $finish;
        end
    end

    task automatic send_item(input lr_op_t op, input logic [S_W-1:0] data,
                             input chk_t chk, input pixel_t px);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        item_chk <= chk;
        item_px <= px;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [S_W-1:0] pack_line(input coord_t x0, input coord_t y0,
                                                 input coord_t x1, input coord_t y1);
        return S_W'({y1, x1, y0, x0});
    endfunction

    function automatic logic [S_W-1:0] noise_data();
        return S_W'({$urandom, $urandom});
    endfunction

    function automatic coord_t nearby(input coord_t v);
        int d;
        d = $urandom_range(12);
        if ($urandom_range(1))
            return (int'(v) + d <= CMAX) ? v + coord_t'(d) : v - coord_t'(d);
        else
            return (int'(v) >= d) ? v - coord_t'(d) : v + coord_t'(d);
    endfunction

    function automatic dir_row_t dir_row(input lr_op_t op, input int x0, input int y0,
                                         input int x1, input int y1, input chk_t chk,
                                         input int px, input int py, input bit pl);
        dir_row_t r;
        r.op = op;
        r.x0 = coord_t'(x0); r.y0 = coord_t'(y0);
        r.x1 = coord_t'(x1); r.y1 = coord_t'(y1);
        r.chk = chk;
        r.px.x = coord_t'(px); r.px.y = coord_t'(py); r.px.is_last = pl;
        return r;
    endfunction

    // Mostly whole short lines; some long or cut-off lines that a new start
    // replaces, and stray steps after a line has ended.
    task automatic drive_lines(input int n_items);
        int     done;
        int     pick;
        int     len;
        int     steps;
        coord_t x0, y0, x1, y1;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            x0 = coord_t'($urandom);
            y0 = coord_t'($urandom);
            if (pick < 12) begin
                x1 = coord_t'($urandom);
                y1 = coord_t'($urandom);
            end else begin
                x1 = nearby(x0);
                y1 = nearby(y0);
            end
            len = int'(span(x0, x1) >= span(y0, y1) ? span(x0, x1) : span(y0, y1)) + 1;
            if (pick < 12)
                steps = $urandom_range(24);
            else if (pick < 22)
                steps = $urandom_range(len);
            else
                steps = len;
            if (steps > len)
                steps = len;
            send_item(OP_START, pack_line(x0, y0, x1, y1), CHK_MODEL, '0);
            done++;
            repeat (steps) begin
                send_item(OP_STEP, noise_data(), CHK_MODEL, '0);
                done++;
            end
            if (pick >= 90 && steps == len) begin
                repeat ($urandom_range(1, 2))
                    send_item(OP_STEP, noise_data(), CHK_MODEL, '0);
            end
        end
    endtask

    initial begin
        dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_NONE, 0, 0, 0));
        // point line at the top corner
        dir_tbl.push_back(dir_row(OP_START, CMAX, CMAX, CMAX, CMAX, CHK_MODEL, 0, 0, 0));
        dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_PIXEL, CMAX, CMAX, 1));
        dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_NONE, 0, 0, 0));
        dir_tbl.push_back(dir_row(OP_START, 0, 0, 1, 0, CHK_MODEL, 0, 0, 0));
        dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_PIXEL, 0, 0, 0));
        dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_PIXEL, 1, 0, 1));
        // full diagonal, major tie, drawn from the second endpoint
        dir_tbl.push_back(dir_row(OP_START, CMAX, 0, 0, CMAX, CHK_MODEL, 0, 0, 0));
        dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0));
        dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0));
        // restart while the diagonal is still active
        dir_tbl.push_back(dir_row(OP_START, 0, CMAX, CMAX, 0, CHK_MODEL, 0, 0, 0));
        dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0));
        // steep line, minor rising, half-way rounding
        dir_tbl.push_back(dir_row(OP_START, 5, 0, 7, 4, CHK_MODEL, 0, 0, 0));
        repeat (5) dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0));
        // steep line, minor falling
        dir_tbl.push_back(dir_row(OP_START, 7, 0, 5, 3, CHK_MODEL, 0, 0, 0));
        repeat (4) dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0));
        dir_tbl.push_back(dir_row(OP_START, 0, 0, CMAX, 0, CHK_MODEL, 0, 0, 0));
        dir_tbl.push_back(dir_row(OP_STEP, 0, 0, 0, 0, CHK_MODEL, 0, 0, 0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].op == OP_STEP)
                send_item(OP_STEP, noise_data(), dir_tbl[i].chk, dir_tbl[i].px);
            else
                send_item(OP_START, pack_line(dir_tbl[i].x0, dir_tbl[i].y0,
                                              dir_tbl[i].x1, dir_tbl[i].y1),
                          dir_tbl[i].chk, dir_tbl[i].px);
        end
        drive_lines(160);

        src_idle = 62;
        sink_idle <= 13;
        drive_lines(160);

        src_idle = 0;
        sink_idle <= 0;
        hold_go <= 1'b1;
        drive_lines(160);
        s_tvalid <= 1'b0;

        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("[incremental_line_rasterizer] OK");
        else
            $display("[incremental_line_rasterizer] ERROR");
        $finish;
    end

endmodule

[incremental_line_rasterizer.f]
rtl/core/lr_pkg.sv
rtl/core/lr_setup.sv
rtl/core/lr_stepper.sv
rtl/core/incremental_line_rasterizer.sv
dv/incremental_line_rasterizer_tb.sv
